// ===== rtl/mfd_pkg.sv =====
`default_nettype none
package mfd_pkg;

  // Register map, word index (byte address / 4)
  localparam logic [2:0] REG_DELAY_TIME  = 3'd0;
  localparam logic [2:0] REG_FEEDBACK    = 3'd1;
  localparam logic [2:0] REG_WET_MIX     = 3'd2;
  localparam logic [2:0] REG_MODE        = 3'd3;
  localparam logic [2:0] REG_SAMPLE_RATE = 3'd4;
  localparam logic [2:0] REG_SMOOTHING   = 3'd5;

  localparam logic [17:0] FB_SCALE    = 18'd62259;   // 0.95 in Q0.16
  localparam logic [23:0] CHORUS_BASE = 24'd503316;  // 30 ms in Q0.24
  localparam logic [17:0] MOD_DEPTH   = 18'd33554;   // 2 ms in Q0.24
  localparam logic [16:0] UNITY_Q16   = 17'h10000;

  typedef struct packed {
    logic [23:0] delay_time;
    logic [16:0] feedback_amount;
    logic [16:0] wet_mix;
    logic        mode;
    logic [17:0] sample_rate;
    logic [15:0] smoothing_coeff;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_MODMUL, ST_MODT, ST_GAIN, ST_SM1, ST_SM1MUL, ST_SM2,
    ST_DMUL, ST_CLAMP, ST_RP, ST_RD0, ST_RD1, ST_Y1, ST_TAP, ST_WR, ST_MX1, ST_MX2
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLR, OP_LOAD, OP_MODMUL, OP_MODT, OP_GAIN, OP_SM1, OP_SM1MUL,
    OP_SM2, OP_DMUL, OP_CLAMP, OP_RP, OP_RD0, OP_RD1, OP_Y1, OP_TAP, OP_WR,
    OP_MX1, OP_MX2
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
  } status_t;

  function automatic logic signed [23:0] sat24(input logic signed [53:0] x);
    logic signed [23:0] r;
    if (x > 54'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (x < -54'sd8388608) begin
      r = -24'sh800000;
    end else begin
      r = x[23:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/mfd_intf.sv =====
`default_nettype none
interface mfd_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] audio_in;
  logic signed [15:0] mod_in;
  modport source(output valid, audio_in, mod_in, input ready);
  modport sink(input valid, audio_in, mod_in, output ready);
endinterface

interface mfd_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] audio_out;
  modport source(output valid, audio_out, input ready);
  modport sink(input valid, audio_out, output ready);
endinterface
`default_nettype wire

// ===== rtl/mfd_ram.sv =====
`default_nettype none
module mfd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 131072
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/mfd_ctrl.sv =====
`default_nettype none
module mfd_ctrl
  import mfd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire status_t status,
  output cmd_t         cmd
);
  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_MX2 && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (status.clr_last) state_next = ST_IDLE;
      ST_IDLE:   if (in_valid) state_next = ST_MODMUL;
      ST_MODMUL: state_next = ST_MODT;
      ST_MODT:   state_next = ST_GAIN;
      ST_GAIN:   state_next = ST_SM1;
      ST_SM1:    state_next = ST_SM1MUL;
      ST_SM1MUL: state_next = ST_SM2;
      ST_SM2:    state_next = ST_DMUL;
      ST_DMUL:   state_next = ST_CLAMP;
      ST_CLAMP:  state_next = ST_RP;
      ST_RP:     state_next = ST_RD0;
      ST_RD0:    state_next = ST_RD1;
      ST_RD1:    state_next = ST_Y1;
      ST_Y1:     state_next = ST_TAP;
      ST_TAP:    state_next = ST_WR;
      ST_WR:     state_next = ST_MX1;
      ST_MX1:    state_next = ST_MX2;
      ST_MX2:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready = (state == ST_IDLE);
    cmd.op   = OP_NONE;
    case (state)
      ST_CLEAR:  cmd.op = OP_CLR;
      ST_IDLE:   if (in_valid) cmd.op = OP_LOAD;
      ST_MODMUL: cmd.op = OP_MODMUL;
      ST_MODT:   cmd.op = OP_MODT;
      ST_GAIN:   cmd.op = OP_GAIN;
      ST_SM1:    cmd.op = OP_SM1;
      ST_SM1MUL: cmd.op = OP_SM1MUL;
      ST_SM2:    cmd.op = OP_SM2;
      ST_DMUL:   cmd.op = OP_DMUL;
      ST_CLAMP:  cmd.op = OP_CLAMP;
      ST_RP:     cmd.op = OP_RP;
      ST_RD0:    cmd.op = OP_RD0;
      ST_RD1:    cmd.op = OP_RD1;
      ST_Y1:     cmd.op = OP_Y1;
      ST_TAP:    cmd.op = OP_TAP;
      ST_WR:     cmd.op = OP_WR;
      ST_MX1:    cmd.op = OP_MX1;
      ST_MX2:    if (out_free) cmd.op = OP_MX2;
      default:   cmd.op = OP_NONE;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/mfd_datapath.sv =====
`default_nettype none
module mfd_datapath
  import mfd_pkg::*;
#(
  parameter int BUFFER_DEPTH = 131072
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cfg_t               cfg,
  input  wire cmd_t               cmd,
  output status_t                 status,
  input  wire logic signed [23:0] audio_in,
  input  wire logic signed [15:0] mod_in,
  output logic signed [23:0]      audio_out
);
  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int DW = AW + 16;
  localparam longint MAXD = longint'(BUFFER_DEPTH) * 65536 - 1;
  localparam logic [DW:0]  SPAN = (DW+1)'(longint'(BUFFER_DEPTH) * 65536);
  localparam logic [AW-1:0] LAST = AW'(BUFFER_DEPTH - 1);

  logic signed [23:0] audio, tap, fb_sample, written;
  logic signed [15:0] modv;
  logic signed [16:0] mod_term;
  logic [15:0]        fb_gain;
  logic signed [31:0] st;
  logic [DW-1:0]      d16;
  logic [AW-1:0]      ip, wp, clr_addr, i0, raddr, waddr;
  logic [15:0]        t;
  logic signed [52:0] prod, acc, shd;
  logic signed [33:0] mul_a, target1, target2;
  logic signed [18:0] mul_b;
  logic [16:0]        fb_knob, wet;
  logic signed [DW:0] rp_raw, rp;
  logic signed [53:0] sum;
  logic [23:0]        rdata, wdata;
  logic               we;

  assign fb_knob = cfg.feedback_amount[16] ? UNITY_Q16 : cfg.feedback_amount;
  assign wet     = cfg.wet_mix[16] ? UNITY_Q16 : cfg.wet_mix;
  assign target1 = cfg.mode ? 34'($signed({1'b0, CHORUS_BASE})) + 34'(mod_term)
                            : 34'($signed({1'b0, cfg.delay_time}));
  assign target2 = 34'($signed({1'b0, cfg.delay_time})) + 34'(mod_term);
  assign shd     = prod >>> 8;
  assign rp_raw  = $signed({1'b0, wp, 16'b0}) - $signed({1'b0, d16});
  assign rp      = rp_raw[DW] ? rp_raw + $signed(SPAN) : rp_raw;
  assign i0      = (ip == '0) ? LAST : ip - 1'b1;
  assign sum     = 54'(acc) + 54'(prod);
  assign status.clr_last = (clr_addr == LAST);
  assign written = sat24(54'(audio) + 54'(prod >>> 16));

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    raddr = i0;
    case (cmd.op)
      OP_MODMUL: begin mul_a = 34'(modv); mul_b = $signed({1'b0, MOD_DEPTH}); end
      OP_MODT:   begin mul_a = 34'($signed({1'b0, fb_knob}));
                       mul_b = $signed({1'b0, FB_SCALE}); end
      OP_GAIN:   begin mul_a = 34'(st) - target1;
                       mul_b = $signed({3'b0, cfg.smoothing_coeff}); end
      OP_SM1MUL: begin mul_a = 34'(st) - target2;
                       mul_b = $signed({3'b0, cfg.smoothing_coeff}); end
      OP_DMUL:   begin mul_a = 34'(st); mul_b = $signed({1'b0, cfg.sample_rate}); end
      OP_RD0:    raddr = i0;
      OP_RD1:    begin raddr = ip; mul_a = 34'($signed(rdata));
                       mul_b = $signed({2'b0, UNITY_Q16 - {1'b0, t}}); end
      OP_Y1:     begin mul_a = 34'($signed(rdata)); mul_b = $signed({3'b0, t}); end
      OP_TAP:    begin mul_a = 34'(fb_sample); mul_b = $signed({3'b0, fb_gain}); end
      OP_WR:     begin mul_a = 34'(audio); mul_b = $signed({2'b0, UNITY_Q16 - wet}); end
      OP_MX1:    begin mul_a = 34'(tap); mul_b = $signed({2'b0, wet}); end
      default:   ;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = wp;
    wdata = written;
    if (cmd.op == OP_CLR) begin
      we    = 1'b1;
      waddr = clr_addr;
      wdata = '0;
    end else if (cmd.op == OP_WR) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= '0;
      st        <= '0;
      fb_sample <= '0;
      clr_addr  <= '0;
    end else begin
      case (cmd.op)
        OP_CLR: clr_addr <= clr_addr + 1'b1;
        OP_SM1: st <= st - prod[47:16];
        OP_SM2: st <= st - prod[47:16];
        OP_WR:  fb_sample <= tap;
        OP_MX2: wp <= (wp == LAST) ? '0 : wp + 1'b1;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.op != OP_NONE) begin
      prod <= mul_a * mul_b;
    end
    case (cmd.op)
      OP_LOAD:  begin audio <= audio_in; modv <= mod_in; end
      OP_MODT:  mod_term <= prod[31:15];
      OP_GAIN:  fb_gain <= prod[31:16];
      OP_CLAMP: begin
        if (shd < 0) begin
          d16 <= '0;
        end else if (shd > 53'(MAXD)) begin
          d16 <= DW'(MAXD);
        end else begin
          d16 <= shd[DW-1:0];
        end
      end
      OP_RP:    begin ip <= rp[DW-1:16]; t <= rp[15:0]; end
      OP_Y1:    acc <= prod;
      OP_TAP:   tap <= sat24(sum >>> 16);
      OP_MX1:   acc <= prod;
      OP_MX2:   audio_out <= sat24(sum >>> 16);
      default:  ;
    endcase
  end

  mfd_ram #(.WIDTH(24), .DEPTH(BUFFER_DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );
endmodule
`default_nettype wire

// ===== rtl/modulated_fractional_delay_unit.sv =====
`default_nettype none
// Channel  Dir  Beat payload                      Handshake
// in_ch    in   audio_in s24 Q1.23, mod_in s16    valid/ready
// out_ch   out  audio_out s24 Q1.23 (saturated)   valid/ready
// apb      in   six 32-bit registers at 4*index   psel/penable, pready tied high
//
// Each accepted sample is stepped through the sequencer, which drives one
// shared 34x19 multiplier and two reads of the single-read-port delay RAM,
// until the result is loaded into out_ch; a new beat is not taken while a
// sample is in flight. Another input beat is taken as soon as the sequencer
// is idle again, even while the last result waits in out_ch.
// After reset a clearing pass zeroes every word of the delay line;
// in_ch.ready stays low until it ends. A stalled output holds the sequencer
// at its last step.
module modulated_fractional_delay_unit
  import mfd_pkg::*;
#(
  parameter int BUFFER_DEPTH = 131072
) (
  input  wire logic        clk,
  input  wire logic        rst,
  mfd_in_if.sink           in_ch,
  mfd_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;
  logic    wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register file: write on the access phase, hold otherwise
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delay_time      <= '0;
      cfg.feedback_amount <= '0;
      cfg.wet_mix         <= '0;
      cfg.mode            <= 1'b0;
      cfg.sample_rate     <= 18'd48000;
      cfg.smoothing_coeff <= 16'd655;
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_DELAY_TIME:  cfg.delay_time      <= pwdata[23:0];
        REG_FEEDBACK:    cfg.feedback_amount <= pwdata[16:0];
        REG_WET_MIX:     cfg.wet_mix         <= pwdata[16:0];
        REG_MODE:        cfg.mode            <= pwdata[0];
        REG_SAMPLE_RATE: cfg.sample_rate     <= pwdata[17:0];
        REG_SMOOTHING:   cfg.smoothing_coeff <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read-back, zero for unmapped addresses; the low address bits are ignored
  always_comb begin
    prdata = '0;
    case (paddr[4:2])
      REG_DELAY_TIME:  prdata = 32'(cfg.delay_time);
      REG_FEEDBACK:    prdata = 32'(cfg.feedback_amount);
      REG_WET_MIX:     prdata = 32'(cfg.wet_mix);
      REG_MODE:        prdata = 32'(cfg.mode);
      REG_SAMPLE_RATE: prdata = 32'(cfg.sample_rate);
      REG_SMOOTHING:   prdata = 32'(cfg.smoothing_coeff);
      default:         prdata = '0;
    endcase
  end

  mfd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  mfd_datapath #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .status    (status),
    .audio_in  (in_ch.audio_in),
    .mod_in    (in_ch.mod_in),
    .audio_out (out_ch.audio_out)
  );
endmodule
`default_nettype wire
